FILE: src/arw_pkg.sv
// Shared types and constants for the anti-replay window block.
package arw_pkg;

  localparam int BITMAP_BITS = 32;
  localparam int WIN_W       = 6;
  localparam int OP_W        = 3;
  localparam int CTX_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int REG_WINDOW  = 0;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(BITMAP_BITS);
  localparam logic [WIN_W-1:0] WINDOW_MAX   = WIN_W'(BITMAP_BITS);

  typedef enum logic [OP_W-1:0] {
    OP_CHECK       = 3'd0,
    OP_RESERVE     = 3'd1,
    OP_RELEASE     = 3'd2,
    OP_RELEASE_CTX = 3'd3,
    OP_COMMIT      = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_REPLAY = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CTX,
    S_SCAN,
    S_TAIL,
    S_FIN,
    S_DONE
  } state_e;

endpackage

FILE: src/arw_if.sv
// Request and response channel interfaces of the anti-replay window block.
interface arw_req_if #(
  parameter int SEQ_BITS = 40
) ();
  logic                      valid;
  logic                      ready;
  logic [arw_pkg::OP_W-1:0]  op;
  logic [arw_pkg::CTX_W-1:0] context_req;
  logic [SEQ_BITS-1:0]       seq;

  modport source (output valid, op, context_req, seq, input ready);
  modport sink   (input valid, op, context_req, seq, output ready);
endinterface

interface arw_rsp_if ();
  logic                         valid;
  logic                         ready;
  logic [arw_pkg::STATUS_W-1:0] status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

FILE: src/anti_replay_window_with_pending.sv
// Top level of the per-context anti-replay window checker with pending reservations.
// Check, commit, unused ops and a reserve refused by the window pass S_CTX and S_DONE; the next
// word is accepted once the result word is registered. Other reserves and both releases scan the
// pending RAM one entry per cycle in S_SCAN, then pass S_TAIL, S_FIN and S_DONE before the next
// word is accepted. A result word held by the sink delays the next result word.
// Reset: ready stays low while S_INIT clears the pending RAM; window length resets to 32.
module anti_replay_window_with_pending #(
  parameter int CONTEXTS        = 4,
  parameter int PENDING_ENTRIES = 128,
  parameter int SEQ_BITS        = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  arw_req_if.sink           req_i,
  arw_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CTX_AW  = CONTEXTS > 1 ? $clog2(CONTEXTS) : 1;
  localparam int PEND_AW = PENDING_ENTRIES > 1 ? $clog2(PENDING_ENTRIES) : 1;
  localparam int ENTRY_W = 1 + arw_pkg::CTX_W + SEQ_BITS;
  localparam int CREC_W  = SEQ_BITS + arw_pkg::BITMAP_BITS;
  localparam int SH_W    = $clog2(arw_pkg::BITMAP_BITS);
  localparam logic [PEND_AW-1:0] PEND_LAST = PEND_AW'(PENDING_ENTRIES - 1);

  arw_pkg::state_e state_q, state_d;
  arw_pkg::status_e res_q, res_d, out_status_q, out_status_d;

  logic [arw_pkg::WIN_W-1:0] window_q, window_d;
  logic [CONTEXTS-1:0]       ctx_vld_q, ctx_vld_d;
  logic                      out_vld_q, out_vld_d;
  logic [PEND_AW-1:0]        cnt_q, cnt_d;
  logic                      chk_vld_q, chk_vld_d;
  logic [PEND_AW-1:0]        chk_idx_q, chk_idx_d;
  logic                      have_free_q, have_free_d;
  logic [PEND_AW-1:0]        free_idx_q, free_idx_d;
  logic                      dup_q, dup_d;
  logic                      done_q, done_d;

  logic [arw_pkg::OP_W-1:0]  op_q;
  logic [arw_pkg::CTX_W-1:0] ctx_q;
  logic                      c_ok_q;
  logic [SEQ_BITS-1:0]       seq_q;

  logic                      req_acc;
  logic                      cfg_wr;
  logic [CTX_AW+1:0]         req_ctx_ext;
  logic [CTX_AW+1:0]         ctx_ext;
  logic [CTX_AW-1:0]         ctx_raddr;
  logic [CTX_AW-1:0]         ctx_addr;

  logic                      ctx_we;
  logic [CREC_W-1:0]         ctx_wdata;
  logic [CREC_W-1:0]         ctx_rdata;

  logic                      pend_we;
  logic [PEND_AW-1:0]        pend_waddr;
  logic [ENTRY_W-1:0]        pend_wdata;
  logic                      pend_re;
  logic [ENTRY_W-1:0]        pend_rdata;

  logic                      ctx_hit;
  logic [SEQ_BITS-1:0]       top;
  logic [arw_pkg::BITMAP_BITS-1:0] bm;
  logic [arw_pkg::WIN_W-1:0] win_eff;
  logic                      above;
  logic [SEQ_BITS-1:0]       down;
  logic [SEQ_BITS-1:0]       up;
  logic                      in_win;
  logic                      bit_set;
  logic                      acceptable;
  logic [arw_pkg::BITMAP_BITS-1:0] bm_shift;
  logic [arw_pkg::BITMAP_BITS-1:0] bm_mark;

  logic                      ent_v;
  logic [arw_pkg::CTX_W-1:0] ent_c;
  logic [SEQ_BITS-1:0]       ent_s;
  logic                      ent_ctx_hit;
  logic                      ent_match;

  assign req_acc     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == arw_pkg::S_IDLE);
  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.status = out_status_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (int'(paddr[2]) == arw_pkg::REG_WINDOW);
  assign prdata = (int'(paddr[2]) == arw_pkg::REG_WINDOW) ? {26'd0, window_q} : 32'd0;

  assign req_ctx_ext = {{CTX_AW{1'b0}}, req_i.context_req};
  assign ctx_ext     = {{CTX_AW{1'b0}}, ctx_q};
  assign ctx_raddr   = req_ctx_ext[CTX_AW-1:0];
  assign ctx_addr    = ctx_ext[CTX_AW-1:0];

  arw_ram #(
    .WIDTH (CREC_W),
    .DEPTH (CONTEXTS)
  ) u_ctx_ram (
    .clk_i   (clk_i),
    .we_i    (ctx_we),
    .waddr_i (ctx_addr),
    .wdata_i (ctx_wdata),
    .re_i    (req_acc),
    .raddr_i (ctx_raddr),
    .rdata_o (ctx_rdata)
  );

  arw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PENDING_ENTRIES)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wdata),
    .re_i    (pend_re),
    .raddr_i (cnt_q),
    .rdata_o (pend_rdata)
  );

  // window test on the context record
  always_comb begin
    ctx_hit  = c_ok_q && ctx_vld_q[ctx_addr];
    top      = ctx_hit ? ctx_rdata[CREC_W-1:arw_pkg::BITMAP_BITS] : '0;
    bm       = ctx_hit ? ctx_rdata[arw_pkg::BITMAP_BITS-1:0] : '0;
    win_eff  = (window_q > arw_pkg::WINDOW_MAX) ? arw_pkg::WINDOW_MAX : window_q;
    above    = seq_q > top;
    down     = top - seq_q;
    up       = seq_q - top;
    in_win   = (down[SEQ_BITS-1:arw_pkg::WIN_W] == '0) &&
               (down[arw_pkg::WIN_W-1:0] < win_eff);
    bit_set  = bm[down[SH_W-1:0]];
    acceptable = c_ok_q && (above || (in_win && !bit_set));
    bm_shift = ((up[SEQ_BITS-1:SH_W] != '0) ? '0 : (bm << up[SH_W-1:0])) |
               arw_pkg::BITMAP_BITS'(1);
    bm_mark  = bm | (arw_pkg::BITMAP_BITS'(1) << down[SH_W-1:0]);
  end

  always_comb begin
    ent_v       = pend_rdata[ENTRY_W-1];
    ent_c       = pend_rdata[SEQ_BITS +: arw_pkg::CTX_W];
    ent_s       = pend_rdata[SEQ_BITS-1:0];
    ent_ctx_hit = ent_v && (ent_c == ctx_q);
    ent_match   = ent_ctx_hit && (ent_s == seq_q);
  end

  always_comb begin
    state_d      = state_q;
    res_d        = res_q;
    out_vld_d    = out_vld_q;
    out_status_d = out_status_q;
    window_d     = cfg_wr ? pwdata[arw_pkg::WIN_W-1:0] : window_q;
    ctx_vld_d    = ctx_vld_q;
    cnt_d        = cnt_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    have_free_d  = have_free_q;
    free_idx_d   = free_idx_q;
    dup_d        = dup_q;
    done_d       = done_q;
    ctx_we       = 1'b0;
    ctx_wdata    = {seq_q, bm_shift};
    pend_we      = 1'b0;
    pend_waddr   = chk_idx_q;
    pend_wdata   = '0;
    pend_re      = 1'b0;

    if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    // evaluate the entry read in the previous cycle
    if (chk_vld_q) begin
      case (op_q)
        arw_pkg::OP_RESERVE: begin
          if (!ent_v && !have_free_q) begin
            have_free_d = 1'b1;
            free_idx_d  = chk_idx_q;
          end
          if (ent_match) begin
            dup_d = 1'b1;
          end
        end
        arw_pkg::OP_RELEASE: begin
          if (ent_match && !done_q) begin
            pend_we = 1'b1;
            done_d  = 1'b1;
          end
        end
        arw_pkg::OP_RELEASE_CTX: begin
          if (ent_ctx_hit) begin
            pend_we = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    case (state_q)
      arw_pkg::S_INIT: begin
        pend_we    = 1'b1;
        pend_waddr = cnt_q;
        cnt_d      = cnt_q + PEND_AW'(1);
        if (cnt_q == PEND_LAST) begin
          cnt_d   = '0;
          state_d = arw_pkg::S_IDLE;
        end
      end
      arw_pkg::S_IDLE: begin
        if (req_acc) begin
          state_d = arw_pkg::S_CTX;
        end
      end
      arw_pkg::S_CTX: begin
        state_d = arw_pkg::S_DONE;
        case (op_q)
          arw_pkg::OP_CHECK: begin
            res_d = acceptable ? arw_pkg::STATUS_OK : arw_pkg::STATUS_REPLAY;
          end
          arw_pkg::OP_COMMIT: begin
            res_d = acceptable ? arw_pkg::STATUS_OK : arw_pkg::STATUS_REPLAY;
            if (acceptable) begin
              ctx_we              = 1'b1;
              ctx_wdata           = above ? {seq_q, bm_shift} : {top, bm_mark};
              ctx_vld_d[ctx_addr] = 1'b1;
            end
          end
          arw_pkg::OP_RESERVE, arw_pkg::OP_RELEASE, arw_pkg::OP_RELEASE_CTX: begin
            res_d = arw_pkg::STATUS_REPLAY;
            if (acceptable || (op_q != arw_pkg::OP_RESERVE)) begin
              cnt_d       = '0;
              have_free_d = 1'b0;
              dup_d       = 1'b0;
              done_d      = 1'b0;
              state_d     = arw_pkg::S_SCAN;
            end
          end
          default: begin
            res_d = arw_pkg::STATUS_OK;
          end
        endcase
      end
      arw_pkg::S_SCAN: begin
        pend_re   = 1'b1;
        chk_vld_d = 1'b1;
        chk_idx_d = cnt_q;
        cnt_d     = cnt_q + PEND_AW'(1);
        if (cnt_q == PEND_LAST) begin
          cnt_d   = '0;
          state_d = arw_pkg::S_TAIL;
        end
      end
      arw_pkg::S_TAIL: begin
        state_d = arw_pkg::S_FIN;
      end
      arw_pkg::S_FIN: begin
        res_d   = arw_pkg::STATUS_OK;
        state_d = arw_pkg::S_DONE;
        if (op_q == arw_pkg::OP_RESERVE) begin
          if (dup_q) begin
            res_d = arw_pkg::STATUS_REPLAY;
          end else if (!have_free_q) begin
            res_d = arw_pkg::STATUS_FULL;
          end else begin
            pend_we    = 1'b1;
            pend_waddr = free_idx_q;
            pend_wdata = {1'b1, ctx_q, seq_q};
          end
        end
      end
      arw_pkg::S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_q;
          state_d      = arw_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = arw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arw_pkg::S_INIT;
      window_q    <= arw_pkg::WINDOW_RESET;
      ctx_vld_q   <= '0;
      out_vld_q   <= 1'b0;
      cnt_q       <= '0;
      chk_vld_q   <= 1'b0;
      have_free_q <= 1'b0;
      dup_q       <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      ctx_vld_q   <= ctx_vld_d;
      out_vld_q   <= out_vld_d;
      cnt_q       <= cnt_d;
      chk_vld_q   <= chk_vld_d;
      have_free_q <= have_free_d;
      dup_q       <= dup_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q        <= res_d;
    out_status_q <= out_status_d;
    chk_idx_q    <= chk_idx_d;
    free_idx_q   <= free_idx_d;
    if (req_acc) begin
      op_q   <= req_i.op;
      ctx_q  <= req_i.context_req;
      c_ok_q <= (int'(req_i.context_req) < CONTEXTS);
      seq_q  <= req_i.seq;
    end
  end

endmodule

FILE: src/arw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module arw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/arw_checker.sv
// Port-level assertions for the anti-replay window block, bound to its top level.
module arw_port_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  rsp_status_i,
  input logic        psel_i,
  input logic        penable_i,
  input logic        pwrite_i,
  input logic [2:0]  paddr_i,
  input logic [31:0] pwdata_i,
  input logic [31:0] prdata_i
);

  logic [1:0] owed_q;
  logic       req_acc;
  logic       rsp_acc;
  logic       win_wr;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;
  assign win_wr  = psel_i && penable_i && pwrite_i && !paddr_i[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else begin
      owed_q <= owed_q + 2'(req_acc) - 2'(rsp_acc);
    end
  end

  a_no_spurious_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_acc |-> (owed_q != 2'd0))
    else $error("response word without an outstanding request");

  a_bounded_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    owed_q != 2'd3)
    else $error("more than two request words outstanding");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_status_i)))
    else $error("stalled response word changed");

  a_window_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_wr |=> (!(psel_i && !paddr_i[2]) || (prdata_i[5:0] == $past(pwdata_i[5:0]))))
    else $error("window length readback differs from the written value");

endmodule

bind anti_replay_window_with_pending arw_port_props u_arw_port_props (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .psel_i       (psel),
  .penable_i    (penable),
  .pwrite_i     (pwrite),
  .paddr_i      (paddr),
  .pwdata_i     (pwdata),
  .prdata_i     (prdata)
);

FILE: tb/sv/arw_checker.sv
// Checker: mirrors the anti-replay window and pending table, compares every status word.
module arw_checker #(
  parameter int CONTEXTS        = 4,
  parameter int PENDING_ENTRIES = 128,
  parameter int SEQ_BITS        = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  arw_req_if          req_i,
  arw_rsp_if          rsp_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned errors_o,
  output int unsigned backlog_o
);
  import arw_pkg::*;

  localparam logic [2:0] ADDR_WINDOW = 3'(4 * REG_WINDOW);

  logic [WIN_W-1:0]         win_size;
  logic [SEQ_BITS-1:0]      top_seq  [CONTEXTS];
  logic [BITMAP_BITS-1:0]   seen     [CONTEXTS];
  logic                     held_v   [PENDING_ENTRIES];
  logic [CTX_W-1:0]         held_ctx [PENDING_ENTRIES];
  logic [SEQ_BITS-1:0]      held_seq [PENDING_ENTRIES];
  status_e                  status_due_q [$];
  status_e                  due;
  int unsigned              misses = 0;

  assign errors_o = misses;

  function automatic bit seq_fresh(input int c, input logic [SEQ_BITS-1:0] s);
    logic [SEQ_BITS-1:0] gap;
    logic [WIN_W-1:0]    span;
    if (s > top_seq[c]) return 1'b1;
    gap  = top_seq[c] - s;
    span = (win_size > WINDOW_MAX) ? WINDOW_MAX : win_size;
    if (gap >= span) return 1'b0;
    return !seen[c][gap[4:0]];
  endfunction

  function automatic status_e reserve_seq(input int c, input logic [SEQ_BITS-1:0] s);
    int slot;
    int i;
    slot = -1;
    if (!seq_fresh(c, s)) return STATUS_REPLAY;
    for (i = 0; i < PENDING_ENTRIES; i++) begin
      if (!held_v[i]) begin
        if (slot < 0) slot = i;
      end else if (held_ctx[i] == CTX_W'(c) && held_seq[i] == s) begin
        return STATUS_REPLAY;
      end
    end
    if (slot < 0) return STATUS_FULL;
    held_v[slot]   = 1'b1;
    held_ctx[slot] = CTX_W'(c);
    held_seq[slot] = s;
    return STATUS_OK;
  endfunction

  function automatic status_e commit_seq(input int c, input logic [SEQ_BITS-1:0] s);
    logic [SEQ_BITS-1:0] gap;
    if (s > top_seq[c]) begin
      gap = s - top_seq[c];
      if (gap >= BITMAP_BITS) seen[c] = '0;
      else seen[c] = seen[c] << gap[4:0];
      seen[c][0] = 1'b1;
      top_seq[c] = s;
      return STATUS_OK;
    end
    if (!seq_fresh(c, s)) return STATUS_REPLAY;
    gap = top_seq[c] - s;
    seen[c][gap[4:0]] = 1'b1;
    return STATUS_OK;
  endfunction

  function automatic status_e apply_word(input logic [OP_W-1:0] op,
                                         input logic [CTX_W-1:0] ctx,
                                         input logic [SEQ_BITS-1:0] s);
    int      c;
    bit      ctx_ok;
    bit      hit;
    int      i;
    status_e st;
    c      = int'(ctx);
    ctx_ok = c < CONTEXTS;
    st     = STATUS_OK;
    hit    = 1'b0;
    case (op)
      OP_CHECK: begin
        st = (ctx_ok && seq_fresh(c, s)) ? STATUS_OK : STATUS_REPLAY;
      end
      OP_RESERVE: begin
        st = ctx_ok ? reserve_seq(c, s) : STATUS_REPLAY;
      end
      OP_RELEASE: begin
        for (i = 0; i < PENDING_ENTRIES; i++) begin
          if (!hit && held_v[i] && held_ctx[i] == ctx && held_seq[i] == s) begin
            held_v[i] = 1'b0;
            hit = 1'b1;
          end
        end
      end
      OP_RELEASE_CTX: begin
        for (i = 0; i < PENDING_ENTRIES; i++) begin
          if (held_v[i] && held_ctx[i] == ctx) held_v[i] = 1'b0;
        end
      end
      OP_COMMIT: begin
        st = ctx_ok ? commit_seq(c, s) : STATUS_REPLAY;
      end
      default: begin
      end
    endcase
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size = WINDOW_RESET;
      foreach (top_seq[k]) begin
        top_seq[k] = '0;
        seen[k]    = '0;
      end
      foreach (held_v[k]) begin
        held_v[k]   = 1'b0;
        held_ctx[k] = '0;
        held_seq[k] = '0;
      end
      status_due_q.delete();
      backlog_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_WINDOW) begin
        win_size = pwdata[WIN_W-1:0];
      end
      // drain before fill: a word accepted now cannot answer itself
      if (rsp_i.valid && rsp_i.ready) begin
        if (status_due_q.size() == 0) begin
          $error("status: expected no word, actual %0d", rsp_i.status);
          misses++;
        end else begin
          due = status_due_q.pop_front();
          if (rsp_i.status !== due) begin
            $error("status: expected %0d, actual %0d", due, rsp_i.status);
            misses++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        status_due_q.push_back(apply_word(req_i.op, req_i.context_req, req_i.seq));
      end
      backlog_o <= status_due_q.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
// Testbench top: clock, reset, request and window-register stimulus, response stalls, verdict.
module tb;
  import arw_pkg::*;

  localparam int CONTEXTS        = 4;
  localparam int PENDING_ENTRIES = 128;
  localparam int SEQ_BITS        = 40;
  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int PHASE_WORDS     = 140;
  localparam int CHOKE_CYCLES    = 600;
  localparam int TIMEOUT_CYCLES  = 3000000;

  localparam logic [2:0]      ADDR_WINDOW = 3'(4 * REG_WINDOW);
  localparam logic [OP_W-1:0] OP_SPARE_LO = OP_W'(OP_COMMIT + 1);
  localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

  typedef enum {RX_STEADY, RX_COIN, RX_EAGER, RX_SPARSE} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned fail_cnt;
  int unsigned backlog;

  logic [SEQ_BITS-1:0] lead [CONTEXTS];
  logic [CTX_W-1:0]    held_ctx_q [$];
  logic [SEQ_BITS-1:0] held_seq_q [$];
  int unsigned         sent;
  int unsigned         burst_left;
  bit                  choke_go;
  bit                  choke_done;

  arw_req_if #(.SEQ_BITS(SEQ_BITS)) req ();
  arw_rsp_if                        rsp ();

  anti_replay_window_with_pending #(
    .CONTEXTS       (CONTEXTS),
    .PENDING_ENTRIES(PENDING_ENTRIES),
    .SEQ_BITS       (SEQ_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  arw_checker #(
    .CONTEXTS       (CONTEXTS),
    .PENDING_ENTRIES(PENDING_ENTRIES),
    .SEQ_BITS       (SEQ_BITS)
  ) chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rsp_i    (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .errors_o (fail_cnt),
    .backlog_o(backlog)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic logic [SEQ_BITS-1:0] draw_seq(input logic [CTX_W-1:0] c);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return lead[c] + SEQ_BITS'($urandom_range(0, 44)) - SEQ_BITS'(36);
    if (pick < 70) return lead[c] + SEQ_BITS'($urandom_range(1, 80));
    if (pick < 80) return lead[c] - SEQ_BITS'($urandom_range(28, 40));
    if (pick < 88) return SEQ_BITS'($urandom_range(0, 63));
    // only the last context is pushed against the top of the sequence space
    if (pick < 97 || c != CTX_W'(CONTEXTS - 1)) return SEQ_BITS'({$urandom, $urandom});
    return '1 - SEQ_BITS'($urandom_range(0, 40));
  endfunction

  task automatic offer(input logic [OP_W-1:0] op, input logic [CTX_W-1:0] c,
                       input logic [SEQ_BITS-1:0] s);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    req.valid       <= 1'b1;
    req.op          <= op;
    req.context_req <= c;
    req.seq         <= s;
    do @(posedge clk_i); while (!req.ready);
    burst_left--;
    sent++;
    if (op == OP_COMMIT && s > lead[c]) lead[c] = s;
  endtask

  task automatic keep(input logic [CTX_W-1:0] c, input logic [SEQ_BITS-1:0] s);
    held_ctx_q.push_back(c);
    held_seq_q.push_back(s);
    if (held_seq_q.size() > 64) begin
      void'(held_ctx_q.pop_front());
      void'(held_seq_q.pop_front());
    end
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (backlog != 0);
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [WIN_W-1:0] win, input bit fill, input bit choke);
    int unsigned         start;
    int unsigned         pick;
    int unsigned         k;
    logic [CTX_W-1:0]    c;
    logic [SEQ_BITS-1:0] s;
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WINDOW;
    pwdata  <= {($urandom_range(0, 1) != 0) ? (32 - WIN_W)'($urandom) : (32 - WIN_W)'(0), win};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (choke) choke_go = 1'b1;
    if (fill) begin
      for (k = 0; k < CONTEXTS; k++) offer(OP_RELEASE_CTX, CTX_W'(k), draw_seq(CTX_W'(k)));
      // spread over the contexts that stay clear of the top of the sequence space
      for (k = 0; k < PENDING_ENTRIES + 8; k++) begin
        c = CTX_W'(k % (CONTEXTS - 1));
        offer(OP_RESERVE, c, lead[c] + SEQ_BITS'(k + 1));
      end
      offer(OP_RESERVE, CTX_W'(0), lead[0] + SEQ_BITS'(1));
      offer(OP_RELEASE, CTX_W'(1), lead[1] + SEQ_BITS'(2));
      offer(OP_RESERVE, CTX_W'(2), lead[2] + SEQ_BITS'(1000));
      offer(OP_RESERVE, CTX_W'(2), lead[2] + SEQ_BITS'(1001));
      for (k = 0; k < CONTEXTS; k++) offer(OP_RELEASE_CTX, CTX_W'(k), draw_seq(CTX_W'(k)));
    end else begin
      start = sent;
      while (sent - start < PHASE_WORDS) begin
        c    = CTX_W'($urandom_range(0, CONTEXTS - 1));
        s    = draw_seq(c);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          offer(OP_RESERVE, c, s);
          if ($urandom_range(0, 4) != 0) offer(OP_COMMIT, c, s);
          if ($urandom_range(0, 9) != 0) offer(OP_RELEASE, c, s);
          else keep(c, s);
        end else if (pick < 60) begin
          offer(OP_CHECK, c, s);
        end else if (pick < 72) begin
          offer(OP_COMMIT, c, s);
        end else if (pick < 80) begin
          offer(OP_RESERVE, c, s);
          keep(c, s);
        end else if (pick < 88 && held_seq_q.size() != 0) begin
          k = $urandom_range(0, held_seq_q.size() - 1);
          offer(OP_RELEASE, held_ctx_q[k], held_seq_q[k]);
          if ($urandom_range(0, 3) != 0) begin
            held_ctx_q.delete(k);
            held_seq_q.delete(k);
          end
        end else if (pick < 91) begin
          offer(OP_RELEASE_CTX, c, s);
        end else if (pick < 95) begin
          offer(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), c, s);
        end else begin
          offer(OP_W'($urandom), CTX_W'($urandom), SEQ_BITS'({$urandom, $urandom}));
        end
      end
    end
  endtask

  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    mode      = RX_STEADY;
    mode_left = 0;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (choke_go && !choke_done) begin
        choke_done = 1'b1;
        hold_left  = CHOKE_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          RX_STEADY: rsp.ready <= 1'b1;
          RX_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
          RX_EAGER:  rsp.ready <= ($urandom_range(0, 3) != 0);
          default:   rsp.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [OP_W-1:0] op;
    req.valid       <= 1'b0;
    req.op          <= OP_CHECK;
    req.context_req <= '0;
    req.seq         <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    foreach (lead[k]) lead[k] = '0;
    sent       = 0;
    burst_left = 0;
    choke_go   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    offer(OP_CHECK,  CTX_W'(0), '0);
    offer(OP_COMMIT, CTX_W'(0), '0);
    offer(OP_COMMIT, CTX_W'(0), '0);
    offer(OP_CHECK,  CTX_W'(0), '1);
    offer(OP_COMMIT, CTX_W'(1), SEQ_BITS'(5));
    offer(OP_COMMIT, CTX_W'(1), SEQ_BITS'(40));
    offer(OP_COMMIT, CTX_W'(1), SEQ_BITS'(9));
    offer(OP_COMMIT, CTX_W'(1), SEQ_BITS'(8));
    offer(OP_COMMIT, CTX_W'(1), SEQ_BITS'(41));
    offer(OP_RESERVE, CTX_W'(2), SEQ_BITS'(100));
    offer(OP_RESERVE, CTX_W'(2), SEQ_BITS'(100));
    offer(OP_CHECK,   CTX_W'(2), SEQ_BITS'(100));
    offer(OP_RELEASE, CTX_W'(2), SEQ_BITS'(100));
    offer(OP_RESERVE, CTX_W'(2), SEQ_BITS'(100));
    offer(OP_COMMIT,  CTX_W'(2), SEQ_BITS'(100));
    offer(OP_RESERVE, CTX_W'(2), SEQ_BITS'(100));
    offer(OP_RELEASE, CTX_W'(3), SEQ_BITS'(7));
    offer(OP_RELEASE_CTX, CTX_W'(2), '0);
    for (op = OP_SPARE_LO; op != OP_SPARE_HI; op++) offer(op, CTX_W'(1), SEQ_BITS'(41));
    offer(OP_SPARE_HI, CTX_W'(1), SEQ_BITS'(41));
    offer(OP_COMMIT, CTX_W'(3), '1);
    offer(OP_CHECK,  CTX_W'(3), '0);
    offer(OP_CHECK,  CTX_W'(3), '1 - SEQ_BITS'(31));
    // distance of exactly 2^32: must not fold back onto bit 0
    offer(OP_COMMIT, CTX_W'(0), SEQ_BITS'(64'h1_0000_0000));
    offer(OP_CHECK,  CTX_W'(0), '0);

    run_phase(WIN_W'(1), 1'b0, 1'b0);
    run_phase(WIN_W'(0), 1'b0, 1'b0);
    run_phase(WINDOW_MAX, 1'b1, 1'b0);
    run_phase('1, 1'b0, 1'b1);
    run_phase(WINDOW_MAX + WIN_W'(1), 1'b0, 1'b0);
    run_phase(WIN_W'($urandom_range(2, 31)), 1'b0, 1'b0);
    run_phase(WIN_W'(16), 1'b1, 1'b0);
    run_phase(WINDOW_MAX, 1'b0, 1'b0);
    run_phase(WIN_W'($urandom_range(2, 31)), 1'b0, 1'b0);
    run_phase(WIN_W'(7), 1'b0, 1'b0);

    settle();
    repeat (PENDING_ENTRIES + 16) @(posedge clk_i);
    if (fail_cnt == 0 && backlog == 0) begin
      $display("anti_replay_window_with_pending test passed");
    end else begin
      $display("anti_replay_window_with_pending test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("anti_replay_window_with_pending test failed");
    $finish;
  end

endmodule

FILE: files.f
src/arw_pkg.sv
src/arw_if.sv
src/arw_ram.sv
src/anti_replay_window_with_pending.sv
src/arw_checker.sv
tb/sv/arw_checker.sv
tb/sv/tb.sv
